### hw/rtl/efd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// efd_pkg
// Types and constants shared by the escaped frame deframer modules.
// ---------------------------------------------------------------------------
package efd_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned SUM_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MAGIC    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CTRL     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd5;

	localparam logic [7:0] RST_MAGIC  = 8'd126;
	localparam logic [7:0] RST_ESCAPE = 8'd125;
	localparam logic [7:0] RST_MASK   = 8'd32;
	localparam logic [7:0] RST_CTRL   = 8'd0;
	localparam logic [7:0] RST_TARGET = 8'd255;
	localparam logic [7:0] RST_LIMIT  = 8'd10;

	localparam logic [7:0] FAIL_MAX   = 8'hff;

	// bytes of framing overhead besides the length value: start, length, type, end
	localparam int unsigned FRAME_OVERHEAD = 4;

	typedef enum logic [1:0] {
		K_PAYLOAD = 2'd0,
		K_FAIL    = 2'd1,
		K_OTHER   = 2'd2,
		K_STOPPED = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_GAP   = 3'd0,
		PH_START = 3'd1,
		PH_LEN   = 3'd2,
		PH_BODY  = 3'd3,
		PH_STOP  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_EVAL  = 3'd1,
		ST_FAIL  = 3'd2,
		ST_STOPK = 3'd3,
		ST_EMIT  = 3'd4
	} seq_t;

	typedef struct packed {
		logic [7:0] magic;
		logic [7:0] escape;
		logic [7:0] mask;
		logic [7:0] ctrl_type;
		logic [7:0] target;
		logic [7:0] limit;
	} cfg_t;

endpackage
`default_nettype wire

### hw/rtl/efd_frame_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// efd_frame_ram
// Frame buffer: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module efd_frame_ram #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### hw/rtl/efd_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// efd_ctrl
// Frame parser, fail accounting, result sequencer and output register.
// ---------------------------------------------------------------------------
module efd_ctrl #(
	parameter int unsigned FRAME_BUF_BYTES = 32,
	parameter int unsigned AW              = $clog2(FRAME_BUF_BYTES)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire efd_pkg::cfg_t     cfg,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              in_cmd,
	input  wire logic [7:0]        in_byte,
	input  wire logic              in_gap,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output efd_pkg::kind_t         out_kind,
	output logic [7:0]             out_byte,
	output logic                   out_last,
	output logic [7:0]             out_total,
	output logic                   ram_we,
	output logic [AW-1:0]          ram_waddr,
	output logic [7:0]             ram_wdata,
	output logic                   ram_re,
	output logic [AW-1:0]          ram_raddr,
	input  wire logic [7:0]        ram_rdata
);

	efd_pkg::seq_t   seq_q, seq_d;
	efd_pkg::phase_t phase_q, phase_d, eff_phase;
	efd_pkg::kind_t  fkind_q, ev_fkind;
	efd_pkg::phase_t ev_fphase;
	efd_pkg::kind_t  push_kind;

	logic                     esc_q, esc_d;
	logic [AW-1:0]            idx_q, idx_d;
	logic [AW-1:0]            len_q, len_d;
	logic [efd_pkg::SUM_W-1:0] sum_q, sum_d;
	logic [7:0]               fc_q, fc_d, fc_inc;
	logic [7:0]               type_q, type_d;
	logic                     stop_q, stop_d;
	logic                     cmd_q, gap_q;
	logic [7:0]               byte_q;

	logic                     ev_fail, ev_clear, ev_drain;
	logic [7:0]               ub, folded;
	logic [AW:0]              tail;

	logic                     slot_free, push, push_last, emit_last;
	logic [7:0]               push_byte;

	logic                     m_valid_q, m_last_q;
	efd_pkg::kind_t           m_kind_q;
	logic [7:0]               m_byte_q, m_total_q;

	assign ub        = esc_q ? (byte_q ^ cfg.mask) : byte_q;
	assign tail      = {1'b0, len_q} + (AW+1)'(3);
	assign folded    = sum_q[7:0] + sum_q[15:8];
	assign fc_inc    = (fc_q == efd_pkg::FAIL_MAX) ? fc_q : fc_q + 8'd1;
	assign emit_last = ({1'b0, idx_q} == ({1'b0, len_q} + (AW+1)'(1)));
	assign slot_free = !m_valid_q || out_ready;

	// Parse one event against the current frame state.
	always_comb begin
		eff_phase = phase_q;
		phase_d   = phase_q;
		esc_d     = esc_q;
		idx_d     = idx_q;
		len_d     = len_q;
		sum_d     = sum_q;
		type_d    = type_q;
		fc_d      = fc_q;
		stop_d    = 1'b0;
		ev_fail   = 1'b0;
		ev_clear  = 1'b0;
		ev_drain  = 1'b0;
		ev_fkind  = efd_pkg::K_FAIL;
		ev_fphase = efd_pkg::PH_GAP;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ub;

		if (phase_q == efd_pkg::PH_GAP) begin
			if (cmd_q) begin
				ev_fail = 1'b1;
			end else if (gap_q) begin
				eff_phase = efd_pkg::PH_START;
			end
		end

		if (!ev_fail) begin
			case (eff_phase)
				efd_pkg::PH_START: begin
					if (cmd_q || byte_q != cfg.magic) begin
						ev_fail = 1'b1;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = '0;
						ram_wdata = cfg.magic;
						phase_d   = efd_pkg::PH_LEN;
						esc_d     = 1'b0;
						sum_d     = '0;
						idx_d     = AW'(1);
					end
				end
				efd_pkg::PH_LEN, efd_pkg::PH_BODY: begin
					if (cmd_q) begin
						ev_fail = 1'b1;
					end else if (!esc_q && byte_q == cfg.escape) begin
						esc_d = 1'b1;
					end else begin
						esc_d = 1'b0;
						if (eff_phase == efd_pkg::PH_LEN) begin
							if (({1'b0, ub} + 9'(efd_pkg::FRAME_OVERHEAD)) >
									9'(FRAME_BUF_BYTES)) begin
								ev_fail = 1'b1;
							end else begin
								len_d     = ub[AW-1:0];
								ram_we    = 1'b1;
								ram_waddr = AW'(1);
								sum_d     = {8'h00, ub};
								idx_d     = AW'(2);
								phase_d   = efd_pkg::PH_BODY;
							end
						end else begin
							ram_we = 1'b1;
							if ({1'b0, idx_q} < tail) begin
								sum_d = sum_q + {8'h00, ub};
								idx_d = idx_q + AW'(1);
								if (idx_q == AW'(2)) begin
									type_d = ub;
								end
							end else if (ub != cfg.magic) begin
								ev_fail = 1'b1;
							end else if (type_q != cfg.ctrl_type) begin
								ev_fail   = 1'b1;
								ev_fkind  = efd_pkg::K_OTHER;
								ev_fphase = efd_pkg::PH_START;
							end else if (folded != cfg.target) begin
								ev_fail = 1'b1;
							end else begin
								ev_clear = 1'b1;
								phase_d  = efd_pkg::PH_START;
								ev_drain = (len_q >= AW'(2));
								idx_d    = AW'(3);
							end
						end
					end
				end
				default: ;
			endcase
		end

		if (ev_fail) begin
			fc_d    = fc_inc;
			stop_d  = (fc_inc >= cfg.limit);
			phase_d = (fc_inc >= cfg.limit) ? efd_pkg::PH_STOP : ev_fphase;
			esc_d   = 1'b0;
		end else if (ev_clear) begin
			fc_d = '0;
		end

		// write the buffer only in the cycle that evaluates the beat
		if (seq_q != efd_pkg::ST_EVAL) begin
			ram_we = 1'b0;
		end
	end

	// Result sequencer.
	always_comb begin
		seq_d     = seq_q;
		in_ready  = 1'b0;
		push      = 1'b0;
		push_kind = efd_pkg::K_FAIL;
		push_byte = '0;
		push_last = 1'b1;
		ram_re    = 1'b0;
		ram_raddr = AW'(3);

		case (seq_q)
			efd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					seq_d = efd_pkg::ST_EVAL;
				end
			end
			efd_pkg::ST_EVAL: begin
				if (phase_q == efd_pkg::PH_STOP) begin
					seq_d = efd_pkg::ST_IDLE;
				end else if (ev_fail) begin
					seq_d = efd_pkg::ST_FAIL;
				end else if (ev_drain) begin
					ram_re = 1'b1;
					seq_d  = efd_pkg::ST_EMIT;
				end else begin
					seq_d = efd_pkg::ST_IDLE;
				end
			end
			efd_pkg::ST_FAIL: begin
				if (slot_free) begin
					push      = 1'b1;
					push_kind = fkind_q;
					push_last = !stop_q;
					seq_d     = stop_q ? efd_pkg::ST_STOPK : efd_pkg::ST_IDLE;
				end
			end
			efd_pkg::ST_STOPK: begin
				if (slot_free) begin
					push      = 1'b1;
					push_kind = efd_pkg::K_STOPPED;
					seq_d     = efd_pkg::ST_IDLE;
				end
			end
			efd_pkg::ST_EMIT: begin
				ram_raddr = idx_q + AW'(1);
				if (slot_free) begin
					push      = 1'b1;
					push_kind = efd_pkg::K_PAYLOAD;
					push_byte = ram_rdata;
					push_last = emit_last;
					// fetch the next byte while this one goes out
					ram_re    = !emit_last;
					if (emit_last) begin
						seq_d = efd_pkg::ST_IDLE;
					end
				end
			end
			default: seq_d = efd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q     <= efd_pkg::ST_IDLE;
			phase_q   <= efd_pkg::PH_GAP;
			esc_q     <= 1'b0;
			idx_q     <= '0;
			len_q     <= '0;
			sum_q     <= '0;
			fc_q      <= '0;
			stop_q    <= 1'b0;
			fkind_q   <= efd_pkg::K_FAIL;
			m_valid_q <= 1'b0;
		end else begin
			seq_q <= seq_d;
			if (seq_q == efd_pkg::ST_EVAL && phase_q != efd_pkg::PH_STOP) begin
				phase_q <= phase_d;
				esc_q   <= esc_d;
				idx_q   <= idx_d;
				len_q   <= len_d;
				sum_q   <= sum_d;
				fc_q    <= fc_d;
				stop_q  <= stop_d;
				fkind_q <= ev_fkind;
			end else if (seq_q == efd_pkg::ST_EMIT && push) begin
				idx_q <= idx_q + AW'(1);
			end
			if (push) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= in_cmd;
			byte_q <= in_byte;
			gap_q  <= in_gap;
		end
		if (seq_q == efd_pkg::ST_EVAL) begin
			type_q <= type_d;
		end
		if (push) begin
			m_kind_q  <= push_kind;
			m_byte_q  <= push_byte;
			m_last_q  <= push_last;
			m_total_q <= fc_q;
		end
	end

	assign out_valid = m_valid_q;
	assign out_kind  = m_kind_q;
	assign out_byte  = m_byte_q;
	assign out_last  = m_last_q;
	assign out_total = m_total_q;

`ifndef SYNTH
	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (seq_q == efd_pkg::ST_EVAL))
		else $error("accepted beat not evaluated next cycle");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == efd_pkg::PH_STOP) |=> (phase_q == efd_pkg::PH_STOP))
		else $error("receiver left stopped phase");

	a_stopped_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_kind_q == efd_pkg::K_STOPPED) |-> m_last_q)
		else $error("stopped beat not marked last");

	a_payload_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_kind_q == efd_pkg::K_PAYLOAD) |-> (m_total_q == 8'd0))
		else $error("payload beat with non-zero fail count");

	a_body_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == efd_pkg::PH_BODY) |-> ({1'b0, idx_q} <= tail))
		else $error("body index ran past frame end");
`endif

endmodule
`default_nettype wire

### hw/rtl/escaped_frame_deframer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// escaped_frame_deframer
// Recovers escaped, delimited, checksummed frames from UART events and
// streams the payload of valid control frames, with fail accounting.
// ---------------------------------------------------------------------------
//
//  channel   dir  tdata                              tuser      tlast
//  s_axis    in   [7:0] rx_byte, [8] idle_gap        cmd        -
//  m_axis    out  [7:0] payload_byte, [15:8] total   kind       last_of_run
//  cfg       in   cfg_index selects register, cfg_wdata is the value
//
//  An event is taken in the idle state and parsed in the evaluate state.
//  A fail then emits one or two result beats, one per cycle while m_tready
//  allows; a good control frame streams L-1 payload bytes, one per cycle while
//  m_tready allows, from the frame buffer's read port, and the input is held
//  until the last payload byte of the frame has gone to the result register.
//  Reset leaves the receiver waiting for an idle gap; the buffer is not cleared.
//  A stalled m_tready holds the result register and the sequencer; s_tready
//  is high only while no event is being processed.
// ---------------------------------------------------------------------------
module escaped_frame_deframer #(
	parameter int unsigned FRAME_BUF_BYTES = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [efd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_wdata,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [15:0]                   s_tdata,  // [7:0] rx_byte, [8] idle_gap
	input  wire logic                          s_tuser,  // [0] cmd
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [15:0]                        m_tdata,  // [7:0] payload_byte, [15:8] fail_total
	output logic [1:0]                         m_tuser,  // [1:0] kind
	output logic                               m_tlast
);

	localparam int unsigned AW = $clog2(FRAME_BUF_BYTES);

	efd_pkg::cfg_t  cfg_q;
	efd_pkg::kind_t out_kind;
	logic [7:0]     out_byte, out_total;

	logic           ram_we, ram_re;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [7:0]     ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic     <= efd_pkg::RST_MAGIC;
			cfg_q.escape    <= efd_pkg::RST_ESCAPE;
			cfg_q.mask      <= efd_pkg::RST_MASK;
			cfg_q.ctrl_type <= efd_pkg::RST_CTRL;
			cfg_q.target    <= efd_pkg::RST_TARGET;
			cfg_q.limit     <= efd_pkg::RST_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				efd_pkg::REG_MAGIC:  cfg_q.magic     <= cfg_wdata;
				efd_pkg::REG_ESCAPE: cfg_q.escape    <= cfg_wdata;
				efd_pkg::REG_MASK:   cfg_q.mask      <= cfg_wdata;
				efd_pkg::REG_CTRL:   cfg_q.ctrl_type <= cfg_wdata;
				efd_pkg::REG_TARGET: cfg_q.target    <= cfg_wdata;
				efd_pkg::REG_LIMIT:  cfg_q.limit     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	efd_ctrl #(
		.FRAME_BUF_BYTES(FRAME_BUF_BYTES),
		.AW             (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tuser),
		.in_byte  (s_tdata[7:0]),
		.in_gap   (s_tdata[8]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_kind (out_kind),
		.out_byte (out_byte),
		.out_last (m_tlast),
		.out_total(out_total),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	efd_frame_ram #(
		.DEPTH(FRAME_BUF_BYTES),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign m_tdata = {out_total, out_byte};
	assign m_tuser = out_kind;

endmodule
`default_nettype wire

### dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for escaped_frame_deframer. UART events go in as
// stream beats from a pending queue; a software deframer predicts the result
// beats, which the monitor checks in order. The run steps through several
// register settings between drained phases and ends with the receiver stop.
// ---------------------------------------------------------------------------
module testbench;

	localparam int unsigned BUF_BYTES    = 32;
	localparam int unsigned MAX_LEN      = BUF_BYTES - efd_pkg::FRAME_OVERHEAD;
	localparam int          RESET_CYCLES = 5;
	localparam int          HOLD_CYCLES  = 600;
	localparam int          DRAIN_CYCLES = 2 * BUF_BYTES + 16;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int          PRINT_LIMIT  = 100;
	localparam int          RANDOM_ITEMS = 12;

	typedef enum int {ESC_NEEDED, ESC_SOME, ESC_ALL} esc_mode_t;
	typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_END, FR_CUT} frame_flaw_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
		logic       idle_gap;
	} rx_event_t;

	typedef struct packed {
		efd_pkg::kind_t kind;
		logic [7:0]     payload;
		logic           run_end;
		logic [7:0]     total;
	} deframe_result_t;

	typedef logic [7:0] byte_q_t[$];

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic [efd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]                    cfg_wdata = '0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [15:0]                   s_tdata   = '0;
	logic                          s_tuser   = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [15:0]                   m_tdata;
	logic [1:0]                    m_tuser;
	logic                          m_tlast;

	escaped_frame_deframer #(.FRAME_BUF_BYTES(BUF_BYTES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rx_event_t       pending_events[$];
	deframe_result_t expected_beats[$];
	deframe_result_t step_beats[$];

	int mismatches  = 0;
	int result_no   = 0;
	int pushed      = 0;
	int offered     = 0;
	int accepted    = 0;
	int send_gap    = 0;
	int stall_left  = 0;
	int hold_left   = 0;
	int hold_asked  = 0;
	int hold_seen   = 0;
	bit quiet       = 1'b0;
	rx_event_t next_event;

	// deframer copy: registers and receive state
	efd_pkg::cfg_t   regs;
	efd_pkg::phase_t rx_phase    = efd_pkg::PH_GAP;
	logic            esc_pending = 1'b0;
	logic [7:0]      frame_buf[BUF_BYTES];
	int              buf_idx     = 0;
	int              frame_len   = 0;
	logic [15:0]     body_sum    = '0;
	logic [7:0]      fail_cnt    = '0;

	function automatic logic [7:0] fold_sum(logic [15:0] s);
		return s[7:0] + s[15:8];
	endfunction

	task automatic note_result(efd_pkg::kind_t k, logic [7:0] b);
		deframe_result_t r;
		r.kind    = k;
		r.payload = b;
		r.run_end = 1'b0;
		r.total   = fail_cnt;
		step_beats.push_back(r);
	endtask

	task automatic count_fail(efd_pkg::kind_t k, efd_pkg::phase_t next_phase);
		if (fail_cnt != efd_pkg::FAIL_MAX)
			fail_cnt++;
		rx_phase    = next_phase;
		esc_pending = 1'b0;
		note_result(k, 8'd0);
		if (fail_cnt >= regs.limit) begin
			rx_phase = efd_pkg::PH_STOP;
			note_result(efd_pkg::K_STOPPED, 8'd0);
		end
	endtask

	task automatic close_frame();
		int         end_idx;
		int         i;
		logic [7:0] folded;
		end_idx = frame_len + 3;
		folded  = fold_sum(body_sum);
		if (frame_buf[end_idx] != regs.magic)
			count_fail(efd_pkg::K_FAIL, efd_pkg::PH_GAP);
		else if (frame_buf[2] != regs.ctrl_type)
			count_fail(efd_pkg::K_OTHER, efd_pkg::PH_START);
		else if (folded != regs.target)
			count_fail(efd_pkg::K_FAIL, efd_pkg::PH_GAP);
		else begin
			fail_cnt = '0;
			rx_phase = efd_pkg::PH_START;
			for (i = 3; i + 1 < end_idx; i++)
				note_result(efd_pkg::K_PAYLOAD, frame_buf[i]);
		end
	endtask

	task automatic deframe_event(rx_event_t ev);
		logic [7:0]      b;
		bit              done;
		deframe_result_t r;
		int              k;
		b    = ev.rx_byte;
		done = 1'b0;
		step_beats.delete();
		if (rx_phase == efd_pkg::PH_STOP)
			done = 1'b1;
		else if (rx_phase == efd_pkg::PH_GAP) begin
			if (ev.cmd) begin
				count_fail(efd_pkg::K_FAIL, efd_pkg::PH_GAP);
				done = 1'b1;
			end else if (ev.idle_gap)
				rx_phase = efd_pkg::PH_START;
			else
				done = 1'b1;
		end
		if (!done) begin
			if (rx_phase == efd_pkg::PH_START) begin
				if (ev.cmd || b != regs.magic)
					count_fail(efd_pkg::K_FAIL, efd_pkg::PH_GAP);
				else begin
					frame_buf[0] = regs.magic;
					rx_phase     = efd_pkg::PH_LEN;
					esc_pending  = 1'b0;
					body_sum     = '0;
					buf_idx      = 1;
				end
			end else if (rx_phase == efd_pkg::PH_LEN || rx_phase == efd_pkg::PH_BODY) begin
				if (ev.cmd)
					count_fail(efd_pkg::K_FAIL, efd_pkg::PH_GAP);
				else if (!esc_pending && b == regs.escape)
					esc_pending = 1'b1;
				else begin
					if (esc_pending)
						b ^= regs.mask;
					esc_pending = 1'b0;
					if (rx_phase == efd_pkg::PH_LEN) begin
						if (int'(b) + efd_pkg::FRAME_OVERHEAD > BUF_BYTES)
							count_fail(efd_pkg::K_FAIL, efd_pkg::PH_GAP);
						else begin
							frame_len    = int'(b);
							frame_buf[1] = b;
							body_sum     = {8'd0, b};
							buf_idx      = 2;
							rx_phase     = efd_pkg::PH_BODY;
						end
					end else begin
						if (buf_idx < BUF_BYTES)
							frame_buf[buf_idx] = b;
						if (buf_idx < frame_len + 3) begin
							body_sum += {8'd0, b};
							buf_idx++;
						end else
							close_frame();
					end
				end
			end
		end
		for (k = 0; k < step_beats.size(); k++) begin
			r         = step_beats[k];
			r.run_end = (k == step_beats.size() - 1);
			expected_beats.push_back(r);
		end
	endtask

	task automatic report(string what, logic [15:0] want, logic [15:0] got);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("result %0d: %s expected %h got %h", result_no, what, want, got);
	endtask

	task automatic next_result_check(deframe_result_t e);
		if (m_tuser !== e.kind)
			report("kind", 16'(e.kind), 16'(m_tuser));
		if (m_tdata[7:0] !== e.payload)
			report("payload_byte", 16'(e.payload), 16'(m_tdata[7:0]));
		if (m_tdata[15:8] !== e.total)
			report("fail_total", 16'(e.total), 16'(m_tdata[15:8]));
		if (m_tlast !== e.run_end)
			report("last_of_run", 16'(e.run_end), 16'(m_tlast));
	endtask

	// check result beats, then predict from any accepted input beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_beats.size() == 0)
					report("unexpected beat", 16'd0, m_tdata);
				else begin
					next_result_check(expected_beats.pop_front());
				end
				result_no++;
			end
			if (s_tvalid && s_tready) begin
				deframe_event({s_tuser, s_tdata[7:0], s_tdata[8]});
				accepted++;
			end
		end
	end

	// sender: hold a beat until taken, then advance or idle for a burst
	always @(negedge clk) begin
		if (offered == accepted) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_events.size() == 0)
				s_tvalid <= 1'b0;
			else if (!quiet && $urandom_range(0, 7) == 0) begin
				send_gap = int'($urandom_range(0, 8));
				s_tvalid <= 1'b0;
			end else begin
				next_event = pending_events.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {7'd0, next_event.idle_gap, next_event.rx_byte};
				s_tuser  <= next_event.cmd;
				offered++;
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_seen != hold_asked) begin
			hold_seen = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = int'($urandom_range(0, 8));
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	task automatic push_event(logic cmd, logic [7:0] b, logic g);
		rx_event_t e;
		e.cmd      = cmd;
		e.rx_byte  = b;
		e.idle_gap = g;
		pending_events.push_back(e);
		pushed++;
	endtask

	task automatic push_value(logic [7:0] v, esc_mode_t esc);
		if (v == regs.escape || esc == ESC_ALL ||
		    (esc == ESC_SOME && $urandom_range(0, 4) == 0)) begin
			push_event(1'b0, regs.escape, $urandom_range(0, 7) == 0);
			push_event(1'b0, v ^ regs.mask, $urandom_range(0, 7) == 0);
		end else
			push_event(1'b0, v, $urandom_range(0, 7) == 0);
	endtask

	task automatic push_frame(logic [7:0] len, logic [7:0] typ, byte_q_t pl,
	                          frame_flaw_t flaw, esc_mode_t esc);
		logic [7:0]  vals[$];
		logic [15:0] csum;
		logic [7:0]  cs;
		int          cut_at;
		int          k;
		push_event(1'b0, regs.magic, 1'b1);
		if (int'(len) > MAX_LEN) begin
			push_value(len, esc);
			return;
		end
		vals.push_back(len);
		vals.push_back(typ);
		for (k = 0; k + 1 < int'(len); k++)
			vals.push_back(k < pl.size() ? pl[k] : 8'($urandom));
		if (len != 0) begin
			csum = '0;
			foreach (vals[i])
				csum += {8'd0, vals[i]};
			// search for a checksum byte that gives the wanted outcome
			cs = 8'($urandom);
			for (k = 0; k < 256; k++) begin
				if ((fold_sum(csum + {8'd0, cs}) == regs.target) == (flaw != FR_BAD_SUM))
					break;
				cs++;
			end
			vals.push_back(cs);
		end
		vals.push_back(flaw == FR_BAD_END ? regs.magic ^ 8'($urandom_range(1, 255))
		                                  : regs.magic);
		cut_at = (flaw == FR_CUT) ? int'($urandom_range(0, vals.size() - 1)) : vals.size();
		for (k = 0; k < cut_at; k++)
			push_value(vals[k], esc);
		if (flaw == FR_CUT)
			push_event(1'b1, 8'($urandom), 1'($urandom));
	endtask

	task automatic push_noise();
		if ($urandom_range(0, 2) == 0)
			push_event(1'b1, 8'($urandom), 1'($urandom));
		else
			push_event(1'b0, 8'($urandom), $urandom_range(0, 3) == 0);
	endtask

	task automatic random_frames(int count);
		int         stop_at;
		int         pick;
		logic [7:0] len;
		byte_q_t    none;
		stop_at = pushed + count;
		while (pushed < stop_at) begin
			pick = int'($urandom_range(0, 99));
			// mostly short frames, now and then up to the buffer size
			len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, MAX_LEN))
			                                  : 8'($urandom_range(0, 5));
			if (pick < 55)
				push_frame(len, regs.ctrl_type, none, FR_GOOD, ESC_SOME);
			else if (pick < 65)
				push_frame(len, regs.ctrl_type ^ 8'($urandom_range(1, 255)), none,
				           FR_GOOD, ESC_SOME);
			else if (pick < 72)
				push_frame(len, regs.ctrl_type, none, FR_BAD_SUM, ESC_SOME);
			else if (pick < 78)
				push_frame(len, regs.ctrl_type, none, FR_BAD_END, ESC_SOME);
			else if (pick < 84)
				push_frame(len, regs.ctrl_type, none, FR_CUT, ESC_SOME);
			else if (pick < 88)
				push_frame(8'($urandom_range(MAX_LEN + 1, 255)), regs.ctrl_type, none,
				           FR_GOOD, ESC_SOME);
			else
				push_noise();
		end
	endtask

	task automatic write_reg(logic [efd_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			efd_pkg::REG_MAGIC:  regs.magic     = val;
			efd_pkg::REG_ESCAPE: regs.escape    = val;
			efd_pkg::REG_MASK:   regs.mask      = val;
			efd_pkg::REG_CTRL:   regs.ctrl_type = val;
			efd_pkg::REG_TARGET: regs.target    = val;
			efd_pkg::REG_LIMIT:  regs.limit     = val;
			default:    ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every beat is sent and answered, then let the block settle
	task automatic drain();
		while (pending_events.size() != 0 || offered != accepted || expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : watchdog
		int unsigned cyc;
		for (cyc = 0; cyc < CYCLE_LIMIT; cyc++)
			@(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		byte_q_t    pl;
		byte_q_t    none;
		logic [7:0] v;
		regs = '{magic: efd_pkg::RST_MAGIC, escape: efd_pkg::RST_ESCAPE,
		         mask: efd_pkg::RST_MASK, ctrl_type: efd_pkg::RST_CTRL,
		         target: efd_pkg::RST_TARGET, limit: efd_pkg::RST_LIMIT};
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: gap wait, escapes, a bad start byte, good, oversized, other-type and cut frames
		push_event(1'b0, 8'hA5, 1'b0);
		push_event(1'b1, 8'h5A, 1'b1);
		pl.push_back(efd_pkg::RST_ESCAPE ^ efd_pkg::RST_MASK);
		pl.push_back(efd_pkg::RST_MAGIC);
		push_frame(8'd3, efd_pkg::RST_CTRL, pl, FR_GOOD, ESC_ALL);
		push_event(1'b0, efd_pkg::RST_MAGIC ^ 8'h01, 1'b1);
		push_frame(8'(MAX_LEN + 1), efd_pkg::RST_CTRL, none, FR_GOOD, ESC_NEEDED);
		push_frame(8'd0, efd_pkg::RST_CTRL ^ 8'h01, none, FR_GOOD, ESC_NEEDED);
		push_frame(8'd2, efd_pkg::RST_CTRL, none, FR_CUT, ESC_NEEDED);
		push_frame(8'd1, efd_pkg::RST_CTRL, none, FR_GOOD, ESC_NEEDED);
		drain();

		// longest frame against a stalled receiver
		write_reg(efd_pkg::REG_LIMIT, 8'd255);
		hold_asked++;
		push_frame(8'(MAX_LEN), regs.ctrl_type, none, FR_GOOD, ESC_SOME);
		push_frame(8'd4, regs.ctrl_type, none, FR_BAD_SUM, ESC_SOME);
		push_frame(8'd4, regs.ctrl_type, none, FR_BAD_END, ESC_SOME);
		random_frames(RANDOM_ITEMS);
		drain();

		write_reg(efd_pkg::REG_MAGIC, 8'd0);
		write_reg(efd_pkg::REG_ESCAPE, 8'd255);
		write_reg(efd_pkg::REG_MASK, 8'd255);
		write_reg(efd_pkg::REG_CTRL, 8'd255);
		write_reg(efd_pkg::REG_TARGET, 8'd0);
		random_frames(RANDOM_ITEMS);
		drain();

		// target equal to the control type lets a zero-length frame pass
		v = 8'($urandom);
		write_reg(efd_pkg::REG_MAGIC, 8'd255);
		write_reg(efd_pkg::REG_ESCAPE, 8'd0);
		write_reg(efd_pkg::REG_MASK, 8'd0);
		write_reg(efd_pkg::REG_CTRL, v);
		write_reg(efd_pkg::REG_TARGET, v);
		random_frames(RANDOM_ITEMS);
		drain();

		quiet = 1'b1;
		write_reg(efd_pkg::REG_MAGIC, 8'($urandom));
		write_reg(efd_pkg::REG_ESCAPE, 8'($urandom));
		write_reg(efd_pkg::REG_MASK, 8'($urandom));
		write_reg(efd_pkg::REG_CTRL, 8'($urandom));
		write_reg(efd_pkg::REG_TARGET, 8'($urandom));
		random_frames(RANDOM_ITEMS);
		drain();

		// lowest limit: next fail stops the receiver, the rest is dropped
		write_reg(efd_pkg::REG_LIMIT, 8'd1);
		push_frame(8'd2, regs.ctrl_type, none, FR_GOOD, ESC_SOME);
		push_event(1'b1, 8'($urandom), 1'($urandom));
		repeat (4) push_noise();
		push_frame(8'd3, regs.ctrl_type, none, FR_GOOD, ESC_SOME);
		drain();

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/efd_pkg.sv
hw/rtl/efd_frame_ram.sv
hw/rtl/efd_ctrl.sv
hw/rtl/escaped_frame_deframer.sv
dv/testbench.sv
